/* sv/tga_rle_pixel_decoder_top_macros.svh */
// Assertion macros for the TGA run-length pixel decoder.
// Included by the modules that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef TGA_RLE_PIXEL_DECODER_TOP_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_TOP_MACROS_SVH

`ifndef SYNTH
`define TGA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tga_rle assertion failed");
`define TGA_ASSERT_NEVER(label, cond) \
  `TGA_ASSERT(label, !(cond))
`else
`define TGA_ASSERT(label, prop)
`define TGA_ASSERT_NEVER(label, cond)
`endif

`endif

/* sv/tga_rle_pkg.sv */
// Shared types and constants of the TGA run-length pixel decoder.
// No dependencies; used by every module of the block.
package tga_rle_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 30;

  localparam logic [CfgIdxW-1:0] CFG_PIXEL_BYTES   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_PIXELS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SWAP_RED_BLUE = 2'd2;

  localparam logic [2:0]  PIXEL_BYTES_RESET  = 3'd3;
  localparam logic [29:0] IMAGE_PIXELS_RESET = 30'd1;

  localparam logic [2:0] PIXEL_BYTES_MIN = 3'd1;
  localparam logic [2:0] PIXEL_BYTES_MAX = 3'd4;
  localparam logic [2:0] SWAP_MIN_BYTES  = 3'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXEL  = 2'd1,
    PH_HALT   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERRUN   = 2'd1,
    STATUS_EARLY_END = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
    status_e     status;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  pixel_bytes;
    logic [29:0] image_pixels;
    logic        swap_red_blue;
  } cfg_t;

endpackage

/* sv/tga_rle_cfg.sv */
// Configuration register bank of the TGA run-length pixel decoder.
// Depends on tga_rle_pkg.
module tga_rle_cfg import tga_rle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PIXEL_BYTES:   cfg_d.pixel_bytes   = cfg_data_i[2:0];
        CFG_IMAGE_PIXELS:  cfg_d.image_pixels  = cfg_data_i[29:0];
        CFG_SWAP_RED_BLUE: cfg_d.swap_red_blue = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_bytes   <= PIXEL_BYTES_RESET;
      cfg_q.image_pixels  <= IMAGE_PIXELS_RESET;
      cfg_q.swap_red_blue <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/tga_rle_core.sv */
// Chunk decoder of the TGA run-length pixel decoder: chunk state and one-byte update.
// Depends on tga_rle_pkg and the assertion macro header.
`include "tga_rle_pixel_decoder_top_macros.svh"

module tga_rle_core import tga_rle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  phase_e      phase_q, phase_d, phase_eff;
  logic        is_run_q, is_run_d, is_run_eff;
  logic [7:0]  left_q, left_d, left_eff;
  logic [7:0]  run_q, run_d, run_eff;
  logic [1:0]  bip_q, bip_d, bip_eff;
  logic [31:0] asm_q, asm_d, asm_eff;
  logic [29:0] rem_q, rem_d, rem_eff;

  logic        restart;
  logic [2:0]  pb;
  logic [7:0]  len;
  logic [31:0] asm_new;
  logic [31:0] pix;
  logic [7:0]  rep_raw;
  logic [7:0]  rep;
  logic        pix_done;
  logic        have_pix;
  logic        stop;

  assign restart = step_i && item_i.first_byte;

  assign phase_eff  = restart ? PH_HEADER : phase_q;
  assign is_run_eff = restart ? 1'b0 : is_run_q;
  assign left_eff   = restart ? 8'd0 : left_q;
  assign run_eff    = restart ? 8'd0 : run_q;
  assign bip_eff    = restart ? 2'd0 : bip_q;
  assign asm_eff    = restart ? 32'd0 : asm_q;
  assign rem_eff    = restart ? cfg_i.image_pixels : rem_q;

  always_comb begin
    if (cfg_i.pixel_bytes < PIXEL_BYTES_MIN) begin
      pb = PIXEL_BYTES_MIN;
    end else if (cfg_i.pixel_bytes > PIXEL_BYTES_MAX) begin
      pb = PIXEL_BYTES_MAX;
    end else begin
      pb = cfg_i.pixel_bytes;
    end
  end

  // Run and literal headers both carry length minus one in bits 6:0.
  assign len = {1'b0, item_i.data_byte[6:0]} + 8'd1;

  always_comb begin
    case (bip_eff)
      2'd0:    asm_new = asm_eff | {24'd0, item_i.data_byte};
      2'd1:    asm_new = asm_eff | {16'd0, item_i.data_byte, 8'd0};
      2'd2:    asm_new = asm_eff | {8'd0, item_i.data_byte, 16'd0};
      default: asm_new = asm_eff | {item_i.data_byte, 24'd0};
    endcase
  end

  assign pix_done = ({1'b0, bip_eff} + 3'd1) >= pb;

  always_comb begin
    pix = asm_new;
    if (cfg_i.swap_red_blue && pb >= SWAP_MIN_BYTES) begin
      pix = {asm_new[31:24], asm_new[7:0], asm_new[15:8], asm_new[23:16]};
    end
  end

  assign rep_raw = is_run_eff ? run_eff : 8'd1;
  assign rep     = ({22'd0, rep_raw} > rem_eff) ? rem_eff[7:0] : rep_raw;

  always_comb begin
    phase_d     = phase_eff;
    is_run_d    = is_run_eff;
    left_d      = left_eff;
    run_d       = run_eff;
    bip_d       = bip_eff;
    asm_d       = asm_eff;
    rem_d       = rem_eff;
    have_pix    = 1'b0;
    stop        = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i && phase_eff != PH_HALT && rem_eff != 30'd0) begin
      case (phase_eff)
        PH_HEADER: begin
          if ({22'd0, len} > rem_eff) begin
            phase_d      = PH_HALT;
            stop         = 1'b1;
            res_valid_o  = 1'b1;
            res_o.status = STATUS_OVERRUN;
          end else begin
            is_run_d = item_i.data_byte[7];
            left_d   = len;
            run_d    = item_i.data_byte[7] ? len : 8'd0;
            bip_d    = 2'd0;
            asm_d    = 32'd0;
            phase_d  = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          if (pix_done) begin
            rem_d = rem_eff - {22'd0, rep};
            if (is_run_eff || left_eff <= 8'd1) begin
              left_d  = 8'd0;
              phase_d = PH_HEADER;
            end else begin
              left_d = left_eff - 8'd1;
            end
            bip_d    = 2'd0;
            asm_d    = 32'd0;
            have_pix = 1'b1;
          end else begin
            bip_d = bip_eff + 2'd1;
            asm_d = asm_new;
          end
        end
        default: ;
      endcase
      if (!stop) begin
        if (item_i.last_byte && rem_d != 30'd0) begin
          phase_d      = PH_HALT;
          res_valid_o  = 1'b1;
          res_o.status = STATUS_EARLY_END;
        end else if (have_pix) begin
          res_valid_o        = 1'b1;
          res_o.pixel_value  = pix;
          res_o.repeat_count = rep;
          res_o.image_done   = (rem_d == 30'd0);
          res_o.status       = STATUS_OK;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
    end else if (step_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_run_q <= 1'b0;
      left_q   <= 8'd0;
      run_q    <= 8'd0;
      bip_q    <= 2'd0;
      asm_q    <= 32'd0;
      rem_q    <= 30'd0;
    end else if (step_i) begin
      is_run_q <= is_run_d;
      left_q   <= left_d;
      run_q    <= run_d;
      bip_q    <= bip_d;
      asm_q    <= asm_d;
      rem_q    <= rem_d;
    end
  end

  `TGA_ASSERT_NEVER(a_halt_silent, phase_q == PH_HALT && step_i && !restart && res_valid_o)
  `TGA_ASSERT(a_rem_never_grows, step_i && !restart |=> rem_q <= $past(rem_q))
  `TGA_ASSERT(a_halt_on_error,
              step_i && res_valid_o && res_o.status != STATUS_OK |=> phase_q == PH_HALT)

endmodule

/* sv/tga_rle_pixel_decoder_top.sv */
// Top level of the TGA run-length pixel decoder: input register, decoder core, result register.
// Depends on tga_rle_pkg, tga_rle_cfg, tga_rle_core and the assertion macro header.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o    in_item_i (in_item_t)
//   out       output     out_valid_o / out_ready_i  out_item_o (out_item_t)
//   cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One byte per cycle while the result register is not stalled.
// The byte register feeds the combinational chunk update, which loads the result register.
// Reset clears the chunk state and loads pixel_bytes 3, image_pixels 1, swap off.
// A stalled result holds; one more byte is buffered in the input register meanwhile.
`include "tga_rle_pixel_decoder_top_macros.svh"

module tga_rle_pixel_decoder_top import tga_rle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q, in_valid_d;
  out_item_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      step;
  logic      res_valid;
  out_item_t res;

  tga_rle_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;
  assign in_valid_d = (in_valid_i && in_ready_o) || (in_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  tga_rle_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_d = step ? res_valid : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `TGA_ASSERT(a_error_fields_zero,
              out_valid_o && out_item_o.status != STATUS_OK |->
              out_item_o.pixel_value == 32'd0 && out_item_o.repeat_count == 8'd0 &&
              !out_item_o.image_done)
  `TGA_ASSERT(a_ok_count_range,
              out_valid_o && out_item_o.status == STATUS_OK |->
              out_item_o.repeat_count != 8'd0 && out_item_o.repeat_count <= 8'd128)
  `TGA_ASSERT_NEVER(a_step_into_stall, step && out_valid_q && !out_ready_i)

endmodule
